@@ hdl/cbf_pkg.sv @@
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared types, constants and saturation helpers of the complex weighted
// beamformer.
// ----------------------------------------------------------------------------
package cbf_pkg;

  // Array and number formats
  localparam int MAX_ANTENNAS     = 20;
  localparam int ANT_W            = 5;
  localparam int SAMPLE_BITS      = 16;
  localparam int WEIGHT_FRAC_BITS = 14;
  localparam int ACC_W            = 24;
  localparam int OUT_W            = 16;
  localparam int IQ_W             = 2 * OUT_W;
  localparam int PROD_W           = 2 * SAMPLE_BITS;
  localparam int TERM_W           = PROD_W + 1 - WEIGHT_FRAC_BITS;

  // Configuration register widths
  localparam int MODE_W       = 1;
  localparam int MAIN_COUNT_W = 5;
  localparam int BACK_COUNT_W = 3;
  localparam int CFG_DATA_W   = 5;
  localparam int CFG_IDX_W    = 2;

  // Reset values of the configuration registers
  localparam logic [MAIN_COUNT_W-1:0] MAIN_COUNT_RST = MAIN_COUNT_W'(16);
  localparam logic [BACK_COUNT_W-1:0] BACK_COUNT_RST = BACK_COUNT_W'(4);

  // Unity weight used for unweighted pass-through
  localparam logic signed [SAMPLE_BITS-1:0] WEIGHT_ONE =
    SAMPLE_BITS'(1 << WEIGHT_FRAC_BITS);

  // Decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_COUNT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_COUNT = CFG_IDX_W'(2);

  // Mode and command codes
  localparam logic MODE_BYPASS  = 1'b0;
  localparam logic MODE_WEIGHTED = 1'b1;
  localparam logic CMD_SAMPLE   = 1'b0;
  localparam logic CMD_WEIGHT   = 1'b1;

  // Which sum a sample feeds
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_MAIN,
    SEL_BACK
  } sum_sel_t;

  // One classified sample travelling from front to back
  typedef struct packed {
    sum_sel_t               sel;
    logic                   emit;
    logic                   eob;
    logic [SAMPLE_BITS-1:0] vr;
    logic [SAMPLE_BITS-1:0] vi;
    logic [SAMPLE_BITS-1:0] wr;
    logic [SAMPLE_BITS-1:0] wi;
  } q_entry_t;

  // Saturate a grown accumulator sum back to the accumulator width
  function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W:0] s);
    logic [ACC_W-1:0] res;
    if (s[ACC_W] != s[ACC_W-1]) begin
      res = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      res = s[ACC_W-1:0];
    end
    return res;
  endfunction

  // Saturate an accumulator to one half of an output word
  function automatic logic [OUT_W-1:0] sat_out(input logic [ACC_W-1:0] a);
    logic [OUT_W-1:0] res;
    if (!a[ACC_W-1] && (a[ACC_W-2:OUT_W-1] != '0)) begin
      res = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (a[ACC_W-1] && (a[ACC_W-2:OUT_W-1] != '1)) begin
      res = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      res = a[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ hdl/cbf_ifs.sv @@
// ----------------------------------------------------------------------------
// cbf_in_if / cbf_out_if
// Valid/ready channels of the beamformer: input items and result items.
// ----------------------------------------------------------------------------
interface cbf_in_if import cbf_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [ANT_W-1:0]              antenna;
  logic signed [SAMPLE_BITS-1:0] value_re;
  logic signed [SAMPLE_BITS-1:0] value_im;
  logic                          last_antenna;
  logic                          end_of_block;

  modport source (
    output valid, cmd, antenna, value_re, value_im, last_antenna, end_of_block,
    input  ready
  );
  modport sink (
    input  valid, cmd, antenna, value_re, value_im, last_antenna, end_of_block,
    output ready
  );
endinterface

interface cbf_out_if import cbf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IQ_W-1:0] main_iq;
  logic [IQ_W-1:0] back_iq;
  logic            block_done;

  modport source (
    output valid, main_iq, back_iq, block_done,
    input  ready
  );
  modport sink (
    input  valid, main_iq, back_iq, block_done,
    output ready
  );
endinterface

@@ hdl/complex_weighted_beamformer.sv @@
// ----------------------------------------------------------------------------
// complex_weighted_beamformer
// Narrowband beamformer: complex samples times stored Q2.14 weights, summed
// into a main and a back beam, emitted on the last antenna or at end of block.
// ----------------------------------------------------------------------------
// The block takes one input item per clock while the queue has room. A weight
// load is written into the weight table at the edge that accepts it and is
// seen by the very next sample. A sample goes through a four-entry queue and
// then three register stages (products, weighted terms, accumulate); a sample
// carrying last_antenna or end_of_block places its result in the output
// register. The accumulator stage takes one sample per cycle unless the output
// register stalls, so the sustained rate is one item per cycle; the back end
// stalls only while a result waits in the output register, and the input
// stays ready until the queue fills.
module complex_weighted_beamformer import cbf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  cbf_in_if.sink                in_ch,
  cbf_out_if.source             out_ch
);

  logic     q_full;
  logic     push_valid;
  q_entry_t push_entry;
  logic     pop;
  logic     head_valid;
  q_entry_t head_entry;

  // Accept, classify and look up weights
  cbf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  // Decouple front and back
  cbf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // Weight, accumulate and emit
  cbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

@@ hdl/cbf_front.sv @@
// ----------------------------------------------------------------------------
// cbf_front
// Accepts input items, holds configuration and the weight table, stores
// weight loads and turns each sample into a classified queue entry.
// ----------------------------------------------------------------------------
module cbf_front import cbf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  cbf_in_if.sink                in_ch,
  input  logic                  q_full,
  output logic                  push_valid,
  output q_entry_t              push_entry
);

  logic                    mode_r;
  logic [MAIN_COUNT_W-1:0] main_count_r;
  logic [BACK_COUNT_W-1:0] back_count_r;
  logic [SAMPLE_BITS-1:0]  wt_re_r [MAX_ANTENNAS];
  logic [SAMPLE_BITS-1:0]  wt_im_r [MAX_ANTENNAS];

  logic                    accept;
  logic                    ant_ok;
  logic [MAIN_COUNT_W:0]   back_limit;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign ant_ok      = in_ch.antenna < ANT_W'(MAX_ANTENNAS);
  assign back_limit  = {1'b0, main_count_r} +
                       (MAIN_COUNT_W + 1)'(back_count_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_BYPASS;
      main_count_r <= MAIN_COUNT_RST;
      back_count_r <= BACK_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:       mode_r       <= cfg_wdata[0];
        CFG_MAIN_COUNT: main_count_r <= cfg_wdata[MAIN_COUNT_W-1:0];
        CFG_BACK_COUNT: back_count_r <= cfg_wdata[BACK_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Store weight loads; clear the table on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ANTENNAS; i++) begin
        wt_re_r[i] <= '0;
        wt_im_r[i] <= '0;
      end
    end else if (accept && (in_ch.cmd == CMD_WEIGHT) && ant_ok) begin
      wt_re_r[in_ch.antenna] <= in_ch.value_re;
      wt_im_r[in_ch.antenna] <= in_ch.value_im;
    end
  end

  // Classify samples and look up their weight
  always_comb begin
    push_valid      = accept && (in_ch.cmd == CMD_SAMPLE);
    push_entry.emit = in_ch.last_antenna || in_ch.end_of_block;
    push_entry.eob  = in_ch.end_of_block;
    push_entry.vr   = in_ch.value_re;
    push_entry.vi   = in_ch.value_im;
    push_entry.wr   = WEIGHT_ONE;
    push_entry.wi   = '0;
    push_entry.sel  = SEL_NONE;
    if (mode_r == MODE_BYPASS) begin
      if (in_ch.antenna == ANT_W'(0)) begin
        push_entry.sel = SEL_MAIN;
      end else if (in_ch.antenna == ANT_W'(1)) begin
        push_entry.sel = SEL_BACK;
      end
    end else if (ant_ok) begin
      push_entry.wr = wt_re_r[in_ch.antenna];
      push_entry.wi = wt_im_r[in_ch.antenna];
      if (in_ch.antenna < main_count_r) begin
        push_entry.sel = SEL_MAIN;
      end else if ({1'b0, in_ch.antenna} < back_limit) begin
        push_entry.sel = SEL_BACK;
      end
    end
  end

`ifndef SYNTHESIS
  a_weight_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_WEIGHT)) |-> !push_valid)
    else $error("weight load produced a queue entry");
`endif

endmodule

@@ hdl/cbf_queue.sv @@
// ----------------------------------------------------------------------------
// cbf_queue
// Short FIFO of classified samples between the front and the back.
// ----------------------------------------------------------------------------
module cbf_queue import cbf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head_entry
);

  q_entry_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full       = count_r == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_entry = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from empty queue");
`endif

endmodule

@@ hdl/cbf_back.sv @@
// ----------------------------------------------------------------------------
// cbf_back
// Weights samples, accumulates the main and back sums and emits packed
// beams through an output register.
// ----------------------------------------------------------------------------
module cbf_back import cbf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  q_entry_t head_entry,
  output logic     pop,
  cbf_out_if.source out_ch
);

  logic                adv;

  // Product stage
  logic                s1_valid_r;
  sum_sel_t            s1_sel_r;
  logic                s1_emit_r;
  logic                s1_eob_r;
  logic [PROD_W-1:0]   p_rr_r, p_ii_r, p_ri_r, p_ir_r;

  // Term stage
  logic                s2_valid_r;
  sum_sel_t            s2_sel_r;
  logic                s2_emit_r;
  logic                s2_eob_r;
  logic [TERM_W-1:0]   t_re_r, t_im_r;
  logic [PROD_W:0]     d_re, d_im;

  // Accumulators and output register
  logic [ACC_W-1:0]    main_re_r, main_im_r, back_re_r, back_im_r;
  logic [ACC_W-1:0]    main_re_nxt, main_im_nxt, back_re_nxt, back_im_nxt;
  logic                out_valid_r;
  logic [IQ_W-1:0]     main_iq_r, back_iq_r;
  logic                block_done_r;

  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && head_valid;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.main_iq    = main_iq_r;
  assign out_ch.back_iq    = back_iq_r;
  assign out_ch.block_done = block_done_r;

  // Multiply sample by weight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sel_r  <= head_entry.sel;
      s1_emit_r <= head_entry.emit;
      s1_eob_r  <= head_entry.eob;
      p_rr_r    <= $signed(head_entry.vr) * $signed(head_entry.wr);
      p_ii_r    <= $signed(head_entry.vi) * $signed(head_entry.wi);
      p_ri_r    <= $signed(head_entry.vr) * $signed(head_entry.wi);
      p_ir_r    <= $signed(head_entry.vi) * $signed(head_entry.wr);
    end
  end

  // Combine products and drop fraction bits (floor)
  assign d_re = $signed({p_rr_r[PROD_W-1], p_rr_r}) - $signed({p_ii_r[PROD_W-1], p_ii_r});
  assign d_im = $signed({p_ri_r[PROD_W-1], p_ri_r}) + $signed({p_ir_r[PROD_W-1], p_ir_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sel_r  <= s1_sel_r;
      s2_emit_r <= s1_emit_r;
      s2_eob_r  <= s1_eob_r;
      t_re_r    <= d_re[PROD_W:WEIGHT_FRAC_BITS];
      t_im_r    <= d_im[PROD_W:WEIGHT_FRAC_BITS];
    end
  end

  // Add the term into its sum with saturation
  always_comb begin
    main_re_nxt = main_re_r;
    main_im_nxt = main_im_r;
    back_re_nxt = back_re_r;
    back_im_nxt = back_im_r;
    case (s2_sel_r)
      SEL_MAIN: begin
        main_re_nxt = sat_acc((ACC_W+1)'($signed(main_re_r)) + (ACC_W+1)'($signed(t_re_r)));
        main_im_nxt = sat_acc((ACC_W+1)'($signed(main_im_r)) + (ACC_W+1)'($signed(t_im_r)));
      end
      SEL_BACK: begin
        back_re_nxt = sat_acc((ACC_W+1)'($signed(back_re_r)) + (ACC_W+1)'($signed(t_re_r)));
        back_im_nxt = sat_acc((ACC_W+1)'($signed(back_im_r)) + (ACC_W+1)'($signed(t_im_r)));
      end
      default: ;
    endcase
  end

  // Update sums; on emission load the output register and clear the sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_re_r   <= '0;
      main_im_r   <= '0;
      back_re_r   <= '0;
      back_im_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r && s2_emit_r;
      if (s2_valid_r) begin
        if (s2_emit_r) begin
          main_re_r <= '0;
          main_im_r <= '0;
          back_re_r <= '0;
          back_im_r <= '0;
        end else begin
          main_re_r <= main_re_nxt;
          main_im_r <= main_im_nxt;
          back_re_r <= back_re_nxt;
          back_im_r <= back_im_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r && s2_emit_r) begin
      main_iq_r    <= {sat_out(main_im_nxt), sat_out(main_re_nxt)};
      back_iq_r    <= {sat_out(back_im_nxt), sat_out(back_re_nxt)};
      block_done_r <= s2_eob_r;
    end
  end

`ifndef SYNTHESIS
  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_valid_r && s2_emit_r) |=>
      (main_re_r == '0) && (main_im_r == '0) && (back_re_r == '0) && (back_im_r == '0))
    else $error("sums not cleared after emission");
`endif

endmodule
